// ===== src/sync_length_frame_receiver_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the frame receiver
// Shared concurrent assertion forms; all sample on clk and are off in reset.
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_FRAME_RECEIVER_TOP_ASSERT_SVH
`define SYNC_LENGTH_FRAME_RECEIVER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SLFR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SLFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SLFR_ASSERT_IMPL(label, ante, cons, msg)
`define SLFR_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== src/slfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame receiver package
// Sizes, header codes and the structs passed between front, queue and back.
// ----------------------------------------------------------------------------
package slfr_pkg;

  // frame store depth per bank and derived index width
  localparam int STORE_DEPTH = 52;
  localparam int POS_W       = $clog2(STORE_DEPTH);

  // two banks: one filling, one draining
  localparam int BANKS = 2;

  // frame descriptor queue
  localparam int DESC_DEPTH = 2;
  localparam int DESC_PTR_W = $clog2(DESC_DEPTH);

  localparam int REM_W         = 7;
  localparam int PAYLOAD_POS_W = 6;

  // header codes
  localparam logic [7:0] START_PREV = 8'hff;
  localparam logic [7:0] START_BYTE = 8'h55;
  localparam logic [REM_W-1:0] REM_MAX = 7'h7f;

  // positions within a frame
  localparam logic [POS_W-1:0] SYNC_POS      = POS_W'(1);
  localparam logic [POS_W-1:0] LEN_POS       = POS_W'(2);
  localparam logic [POS_W:0]   PAYLOAD_START = (POS_W+1)'(3);
  localparam logic [POS_W:0]   LAST_POS      = (POS_W+1)'(STORE_DEPTH - 1);

  // store write from the front
  typedef struct packed {
    logic             en;
    logic             bank;
    logic [POS_W-1:0] addr;
    logic [7:0]       data;
  } wr_req_t;

  // completed frame: bank and payload length
  typedef struct packed {
    logic             bank;
    logic [POS_W-1:0] count;
  } desc_t;

  // bank handed back once fully read
  typedef struct packed {
    logic en;
    logic bank;
  } rel_t;

endpackage

// ===== src/sync_length_frame_receiver_top.sv =====
// ----------------------------------------------------------------------------
// Sync/length frame receiver
// Input: one word per cycle until both store banks hold undrained frames.
// Output: once the drain takes the queued descriptor, one payload word per
// cycle while out_stall is low, set by the single store read port.
// Reset clears header, position and drain state; store contents are not cleared.
// ----------------------------------------------------------------------------
module sync_length_frame_receiver_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_rx_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [7:0]                          out_payload_byte,
  output logic [slfr_pkg::PAYLOAD_POS_W-1:0]  out_payload_pos,
  output logic                                out_payload_last
);

  slfr_pkg::wr_req_t wr;
  slfr_pkg::desc_t   push_desc;
  slfr_pkg::desc_t   pop_desc;
  slfr_pkg::rel_t    rel;
  logic              push, pop, fifo_empty, fifo_full;

  slfr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_rx_byte  (in_rx_byte),
    .wr_o        (wr),
    .push_o      (push),
    .desc_o      (push_desc),
    .fifo_full_i (fifo_full),
    .rel_i       (rel)
  );

  slfr_desc_fifo u_desc_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_data_i (push_desc),
    .pop_i       (pop),
    .pop_data_o  (pop_desc),
    .empty_o     (fifo_empty),
    .full_o      (fifo_full)
  );

  slfr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .wr_i             (wr),
    .fifo_empty_i     (fifo_empty),
    .fifo_data_i      (pop_desc),
    .pop_o            (pop),
    .rel_o            (rel),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_payload_byte (out_payload_byte),
    .out_payload_pos  (out_payload_pos),
    .out_payload_last (out_payload_last)
  );

endmodule

// ===== src/slfr_front.sv =====
// ----------------------------------------------------------------------------
// Frame receiver front end
// Tracks header, length and position, writes each word into the filling
// bank and posts a descriptor when a frame completes.
// ----------------------------------------------------------------------------
`include "sync_length_frame_receiver_top_assert.svh"

module slfr_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_rx_byte,
  output slfr_pkg::wr_req_t    wr_o,
  output logic                 push_o,
  output slfr_pkg::desc_t      desc_o,
  input  logic                 fifo_full_i,
  input  slfr_pkg::rel_t       rel_i
);

  logic [7:0]                        prev_r, prev_nxt;
  logic                              in_frame_r, in_frame_nxt;
  logic [slfr_pkg::POS_W-1:0]        wp_r, wp_nxt;
  logic [slfr_pkg::REM_W-1:0]        rem_r, rem_nxt;
  logic                              fill_bank_r, fill_bank_nxt;
  logic [slfr_pkg::BANKS-1:0]        busy_r, busy_nxt;

  logic                              accept;
  logic                              in_frame_mid;
  logic [slfr_pkg::POS_W-1:0]        wp_eff;
  logic [slfr_pkg::POS_W:0]          wp_inc;
  logic [slfr_pkg::REM_W-1:0]        rem_step;
  logic                              done;

  // hold off while the filling bank still waits to be drained or the descriptor queue is full
  assign in_stall = busy_r[fill_bank_r] || fifo_full_i;
  assign accept   = in_valid && !in_stall;

  // header detection and length countdown
  always_comb begin
    wp_eff       = wp_r;
    in_frame_mid = in_frame_r;
    prev_nxt     = prev_r;
    rem_step     = rem_r;
    if ((in_rx_byte == slfr_pkg::START_BYTE) && !in_frame_r) begin
      if (prev_r == slfr_pkg::START_PREV) begin
        wp_eff       = slfr_pkg::SYNC_POS;
        in_frame_mid = 1'b1;
      end
    end else begin
      prev_nxt = in_rx_byte;
      if (in_frame_r) begin
        if (wp_r == slfr_pkg::LEN_POS) begin
          rem_step = in_rx_byte[7] ? slfr_pkg::REM_MAX : in_rx_byte[6:0];
        end else if (wp_r > slfr_pkg::LEN_POS) begin
          rem_step = rem_r - 1'b1;
        end
      end
    end
  end

  // advance position: overflow first, then completion
  always_comb begin
    wp_inc       = {1'b0, wp_eff} + 1'b1;
    done         = 1'b0;
    wp_nxt       = wp_r;
    in_frame_nxt = in_frame_r;
    rem_nxt      = rem_r;
    if (accept) begin
      rem_nxt = rem_step;
      if (wp_inc > slfr_pkg::LAST_POS) begin
        wp_nxt       = '0;
        in_frame_nxt = 1'b0;
      end else if (in_frame_mid && (rem_step == '0) &&
                   (wp_inc > slfr_pkg::PAYLOAD_START)) begin
        done         = 1'b1;
        wp_nxt       = '0;
        in_frame_nxt = 1'b0;
      end else begin
        wp_nxt       = wp_inc[slfr_pkg::POS_W-1:0];
        in_frame_nxt = in_frame_mid;
      end
    end
  end

  // store write, descriptor post and bank bookkeeping
  always_comb begin
    wr_o.en      = accept;
    wr_o.bank    = fill_bank_r;
    wr_o.addr    = wp_eff;
    wr_o.data    = in_rx_byte;
    push_o       = done;
    desc_o.bank  = fill_bank_r;
    desc_o.count = slfr_pkg::POS_W'(wp_inc - slfr_pkg::PAYLOAD_START);
    busy_nxt      = busy_r;
    fill_bank_nxt = fill_bank_r;
    if (rel_i.en) begin
      busy_nxt[rel_i.bank] = 1'b0;
    end
    if (done) begin
      busy_nxt[fill_bank_r] = 1'b1;
      fill_bank_nxt         = !fill_bank_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      in_frame_r  <= 1'b0;
      wp_r        <= '0;
      rem_r       <= '0;
      fill_bank_r <= 1'b0;
      busy_r      <= '0;
    end else begin
      if (accept) begin
        prev_r <= prev_nxt;
      end
      in_frame_r  <= in_frame_nxt;
      wp_r        <= wp_nxt;
      rem_r       <= rem_nxt;
      fill_bank_r <= fill_bank_nxt;
      busy_r      <= busy_nxt;
    end
  end

  `SLFR_ASSERT_IMPL(a_wr_free_bank, wr_o.en, !busy_r[wr_o.bank], "write into busy bank")
  `SLFR_ASSERT_IMPL(a_rel_busy, rel_i.en, busy_r[rel_i.bank], "release of idle bank")
  `SLFR_ASSERT_IMPL(a_push_len, push_o, (desc_o.count != '0) && !fifo_full_i,
                    "bad frame post")
  `SLFR_ASSERT_NEXT(a_push_swap, push_o, fill_bank_r != $past(fill_bank_r),
                    "bank not swapped after frame")

endmodule

// ===== src/slfr_desc_fifo.sv =====
// ----------------------------------------------------------------------------
// Frame descriptor queue
// Short FIFO of completed frames between the front end and the drain.
// ----------------------------------------------------------------------------
module slfr_desc_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  input  slfr_pkg::desc_t  push_data_i,
  input  logic             pop_i,
  output slfr_pkg::desc_t  pop_data_o,
  output logic             empty_o,
  output logic             full_o
);

  slfr_pkg::desc_t                 ent_r [slfr_pkg::DESC_DEPTH];
  logic [slfr_pkg::DESC_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [slfr_pkg::DESC_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [slfr_pkg::DESC_PTR_W:0]   cnt_r, cnt_nxt;
  logic                            do_push, do_pop;

  assign empty_o    = (cnt_r == '0);
  assign full_o     = (cnt_r == (slfr_pkg::DESC_PTR_W+1)'(slfr_pkg::DESC_DEPTH));
  assign pop_data_o = ent_r[rd_ptr_r];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  // pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entries carry no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_data_i;
    end
  end

endmodule

// ===== src/slfr_back.sv =====
// ----------------------------------------------------------------------------
// Frame receiver drain
// Holds the banked frame store, takes one descriptor at a time and reads
// the payload out word by word into the output register.
// ----------------------------------------------------------------------------
`include "sync_length_frame_receiver_top_assert.svh"

module slfr_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  slfr_pkg::wr_req_t                   wr_i,
  input  logic                                fifo_empty_i,
  input  slfr_pkg::desc_t                     fifo_data_i,
  output logic                                pop_o,
  output slfr_pkg::rel_t                      rel_o,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [7:0]                          out_payload_byte,
  output logic [slfr_pkg::PAYLOAD_POS_W-1:0]  out_payload_pos,
  output logic                                out_payload_last
);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_DRAIN = 2'b10
  } drain_state_t;

  // two banks of frame store
  logic [7:0] store_mem_r [slfr_pkg::BANKS][slfr_pkg::STORE_DEPTH];

  drain_state_t                      state_r, state_nxt;
  logic                              bank_r;
  logic [slfr_pkg::POS_W-1:0]        cnt_r;
  logic [slfr_pkg::POS_W-1:0]        k_r, k_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [7:0]                        rd_data_r;
  logic [slfr_pkg::PAYLOAD_POS_W-1:0] pos_r;
  logic                              last_r;
  logic                              rd_issue, last_rd;

  assign out_valid        = out_valid_r;
  assign out_payload_byte = rd_data_r;
  assign out_payload_pos  = pos_r;
  assign out_payload_last = last_r;

  // read when the output register is empty or being taken
  assign pop_o     = (state_r == S_IDLE) && !fifo_empty_i;
  assign rd_issue  = (state_r == S_DRAIN) && (!out_valid_r || !out_stall);
  assign last_rd   = (k_r == cnt_r - 1'b1);
  assign rel_o.en   = rd_issue && last_rd;
  assign rel_o.bank = bank_r;

  // drain sequencing
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (pop_o) begin
          state_nxt = S_DRAIN;
          k_nxt     = '0;
        end
      end
      S_DRAIN: begin
        if (rd_issue) begin
          out_valid_nxt = 1'b1;
          k_nxt         = k_r + 1'b1;
          if (last_rd) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // descriptor capture
  always_ff @(posedge clk) begin
    if (pop_o) begin
      bank_r <= fifo_data_i.bank;
      cnt_r  <= fifo_data_i.count;
    end
  end

  // store write port
  always_ff @(posedge clk) begin
    if (wr_i.en) begin
      store_mem_r[wr_i.bank][wr_i.addr] <= wr_i.data;
    end
  end

  // registered read straight into the output word
  always_ff @(posedge clk) begin
    if (rd_issue) begin
      rd_data_r <= store_mem_r[bank_r][k_r + slfr_pkg::POS_W'(3)];
      pos_r     <= slfr_pkg::PAYLOAD_POS_W'(k_r);
      last_r    <= last_rd;
    end
  end

  `SLFR_ASSERT_IMPL(a_pop_idle, pop_o, (state_r == S_IDLE) && !fifo_empty_i,
                    "descriptor taken while draining")
  `SLFR_ASSERT_IMPL(a_rel_last, rel_o.en, rd_issue && last_rd, "early bank release")
  `SLFR_ASSERT_NEXT(a_last_flag, rd_issue && last_rd, out_valid_r && last_r,
                    "final word not flagged")
  `SLFR_ASSERT_IMPL(a_no_bank_clash, rd_issue && wr_i.en, wr_i.bank != bank_r,
                    "write into bank being drained")

endmodule

// ===== sim/tb_sync_length_frame_receiver_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for the sync/length frame receiver
// Feeds received bytes with random gaps and output stalls. A behavioral
// deframer predicts every payload word, and each word is checked in order.
// A short directed table comes first, then random frames, broken frames and
// noise.
// ----------------------------------------------------------------------------
module tb_sync_length_frame_receiver_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES = 370;
  localparam int DRAIN_CYCLES = 20;
  localparam int N_DIRECTED   = 23;

  // one payload word as seen on the result channel
  typedef struct packed {
    logic [7:0]                         data;
    logic [slfr_pkg::PAYLOAD_POS_W-1:0] idx;
    logic                               last;
  } payload_word_t;

  // directed row: byte to send, and a hand-typed expectation where one is given
  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    logic       has_word;
    logic [7:0] word;
  } dir_row_t;

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_stall;
  logic [7:0]                          in_rx_byte;
  logic                                out_valid;
  logic                                out_stall;
  logic [7:0]                          out_payload_byte;
  logic [slfr_pkg::PAYLOAD_POS_W-1:0]  out_payload_pos;
  logic                                out_payload_last;

  sync_length_frame_receiver_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_payload_byte (out_payload_byte),
    .out_payload_pos  (out_payload_pos),
    .out_payload_last (out_payload_last)
  );

  // deframer state kept by the testbench
  logic [7:0]                 rx_store [slfr_pkg::STORE_DEPTH];
  int unsigned                rx_pos = 0;
  bit                         rx_in_frame = 0;
  logic [7:0]                 rx_prev = 8'h00;
  logic [slfr_pkg::REM_W-1:0] rx_remaining = '0;

  payload_word_t expected_words[$];
  dir_row_t      directed_rows [N_DIRECTED];
  int            errs = 0;
  int            rand_sent = 0;
  bit            tx_calm = 0;
  bit            rcv_calm = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // advance the deframer by one received byte, queue any payload words it frees
  function automatic void deframe_byte(input logic [7:0] c);
    int unsigned cnt;
    payload_word_t w;
    if (c == slfr_pkg::START_BYTE && !rx_in_frame) begin
      // idle sync byte: never becomes the previous byte
      if (rx_prev == slfr_pkg::START_PREV) begin
        rx_pos      = 1;
        rx_in_frame = 1'b1;
      end
    end else begin
      rx_prev = c;
      if (rx_in_frame) begin
        if (rx_pos == 2)
          rx_remaining = (c > slfr_pkg::REM_MAX) ? slfr_pkg::REM_MAX : c[6:0];
        else if (rx_pos > 2)
          rx_remaining = rx_remaining - 1'b1;
      end
    end
    rx_store[rx_pos] = c;
    rx_pos++;
    // overflow wins over completion
    if (rx_pos > slfr_pkg::STORE_DEPTH - 1) begin
      rx_pos      = 0;
      rx_in_frame = 1'b0;
    end
    if (rx_in_frame && rx_remaining == 0 && rx_pos > 3) begin
      cnt = rx_pos - 3;
      for (int k = 0; k < cnt; k++) begin
        w.data = rx_store[3 + k];
        w.idx  = slfr_pkg::PAYLOAD_POS_W'(k);
        w.last = (k + 1 == cnt);
        expected_words.push_back(w);
      end
      rx_in_frame = 1'b0;
      rx_pos      = 0;
    end
  endfunction

  // payload content biased toward the header codes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return slfr_pkg::START_PREV;
      1: return slfr_pkg::START_BYTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // send one byte; typed rows replace the predicted words with the typed one
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input bit has_word = 1'b0, input logic [7:0] word = 8'h00);
    int gap;
    int n0;
    payload_word_t w;
    gap = tx_calm ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    n0 = expected_words.size();
    deframe_byte(b);
    if (typed) begin
      while (expected_words.size() > n0) void'(expected_words.pop_back());
      if (has_word) begin
        w.data = word;
        w.idx  = '0;
        w.last = 1'b1;
        expected_words.push_back(w);
      end
    end
  endtask

  // frame header followed by a length byte
  task automatic send_header(input logic [7:0] len);
    send_byte(slfr_pkg::START_PREV);
    send_byte(slfr_pkg::START_BYTE);
    send_byte(len);
  endtask

  // result side: random stall per word, check against the oldest expectation
  initial begin
    int n;
    payload_word_t got;
    payload_word_t exp_w;
    out_stall = 1'b0;
    forever begin
      n = rcv_calm ? 0 : $urandom_range(0, 8);
      if (n > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(rst_n && out_valid && !out_stall));
      got = '{out_payload_byte, out_payload_pos, out_payload_last};
      if (expected_words.size() == 0) begin
        errs++;
        $display("%0t: unexpected word byte=%02h pos=%0d last=%0b",
                 $time, got.data, got.idx, got.last);
      end else begin
        exp_w = expected_words.pop_front();
        if (got !== exp_w) begin
          errs++;
          $display("%0t: mismatch expected byte=%02h pos=%0d last=%0b, got byte=%02h pos=%0d last=%0b",
                   $time, exp_w.data, exp_w.idx, exp_w.last, got.data, got.idx, got.last);
        end
      end
      if ($urandom_range(0, 31) == 0) rcv_calm = !rcv_calm;
    end
  end

  // stimulus
  initial begin
    int kind;
    int len;
    int n;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = 8'h00;

    // directed rows: header corner cases and short frames
    directed_rows = '{
      '{8'h55, 1'b1, 1'b0, 8'h00},  // sync byte right after reset: no start
      '{8'hff, 1'b1, 1'b0, 8'h00},
      '{8'h55, 1'b1, 1'b0, 8'h00},  // start
      '{8'h01, 1'b1, 1'b0, 8'h00},  // length one
      '{8'h00, 1'b1, 1'b1, 8'h00},  // lowest payload value
      '{8'hff, 1'b1, 1'b0, 8'h00},
      '{8'h55, 1'b1, 1'b0, 8'h00},
      '{8'h01, 1'b1, 1'b0, 8'h00},
      '{8'hff, 1'b1, 1'b1, 8'hff},  // highest payload value, leaves prev at ff
      '{8'h55, 1'b1, 1'b0, 8'h00},  // starts off the payload ff
      '{8'h02, 1'b1, 1'b0, 8'h00},
      '{8'h55, 1'b0, 1'b0, 8'h00},  // sync byte inside a frame is payload
      '{8'ha5, 1'b0, 1'b0, 8'h00},
      '{8'h00, 1'b1, 1'b0, 8'h00},  // idle byte still stored
      '{8'hff, 1'b1, 1'b0, 8'h00},
      '{8'h7f, 1'b1, 1'b0, 8'h00},
      '{8'h55, 1'b1, 1'b0, 8'h00},  // prev is not ff: no start
      '{8'hff, 1'b1, 1'b0, 8'h00},
      '{8'h55, 1'b1, 1'b0, 8'h00},
      '{8'h03, 1'b1, 1'b0, 8'h00},
      '{8'h12, 1'b0, 1'b0, 8'h00},
      '{8'h34, 1'b0, 1'b0, 8'h00},
      '{8'h56, 1'b0, 1'b0, 8'h00}
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].rx, directed_rows[i].typed,
                directed_rows[i].has_word, directed_rows[i].word);

    // random bursts: mostly good frames, some broken frames and noise
    while (rand_sent < RANDOM_BYTES) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      kind    = $urandom_range(0, 99);
      if (kind < 55) begin
        case ($urandom_range(0, 9))
          0:       len = 48;
          1:       len = $urandom_range(30, 47);
          default: len = $urandom_range(1, 8);
        endcase
        send_header(8'(len));
        for (int i = 0; i < len; i++) send_byte(pick_byte());
        rand_sent += len + 3;
      end else if (kind < 65) begin
        // length zero: runs until overflow
        n = $urandom_range(10, 52);
        send_header(8'h00);
        for (int i = 0; i < n; i++) send_byte(pick_byte());
        rand_sent += n + 3;
      end else if (kind < 75) begin
        // length too long to fit, incl. saturated values
        n = $urandom_range(5, 52);
        send_header(8'($urandom_range(49, 255)));
        for (int i = 0; i < n; i++) send_byte(pick_byte());
        rand_sent += n + 3;
      end else if (kind < 85) begin
        // truncated frame: next burst lands inside it
        len = $urandom_range(2, 8);
        n   = $urandom_range(0, len - 1);
        send_header(8'(len));
        for (int i = 0; i < n; i++) send_byte(pick_byte());
        rand_sent += n + 3;
      end else begin
        n = $urandom_range(1, 60);
        for (int i = 0; i < n; i++) send_byte(pick_byte());
        rand_sent += n;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;

    // drain, then watch for stray words
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errs == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
